[hw/rtl/dtjd_pkg.sv]
// ----------------------------------------------------------------------------
// dtjd_pkg
// Types and constants shared by the date to Julian day number pipeline.
// ----------------------------------------------------------------------------
package dtjd_pkg;

	// One calendar date and time of day, as taken in
	typedef struct packed {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} date_t;

	// One result: validity, day number and fraction of the day
	typedef struct packed {
		logic        status;
		logic [24:0] day_number;
		logic [31:0] day_fraction;
	} jd_t;

	// Fixed-point width of the day fraction before it is cut to 32 bits
	localparam int unsigned FRACTION_BITS = 32;

	// 86400 = 675 << 7, so the fraction is a division by the odd part only
	localparam int unsigned DAY_SHIFT = 7;
	localparam logic [63:0] DAY_ODD   = 64'd675;

	// floor(x / 675) = (x * RECIP_675) >> RECIP_675_SHIFT for x below 2^26
	localparam logic [26:0] RECIP_675       = 27'd101806633;
	localparam int unsigned RECIP_675_SHIFT = 36;

	// floor(y / 100) = (y * RECIP_100) >> 24 for any 16-bit year
	localparam logic [17:0] RECIP_100 = 18'd167773;

	// Fliegel and van Flandern offsets
	localparam logic [25:0] JDN_BIAS  = 26'd32075;
	localparam logic [16:0] YEAR_OFS  = 17'd4800;
	localparam logic [9:0]  CENT_OFS  = 10'd49;
	localparam logic [26:0] DAYS_4YR  = 27'd1461;

	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

	// Days in each month of a common year; zero for codes that are no month
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		case (m)
			4'd1:    len = 5'd31;
			4'd2:    len = 5'd28;
			4'd3:    len = 5'd31;
			4'd4:    len = 5'd30;
			4'd5:    len = 5'd31;
			4'd6:    len = 5'd30;
			4'd7:    len = 5'd31;
			4'd8:    len = 5'd31;
			4'd9:    len = 5'd30;
			4'd10:   len = 5'd31;
			4'd11:   len = 5'd30;
			4'd12:   len = 5'd31;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// 367 * (month - 2 + 12 * early) / 12, with the year starting in March
	function automatic logic [8:0] month_term(input logic [3:0] m);
		logic [8:0] t;
		case (m)
			4'd1:    t = 9'd336;
			4'd2:    t = 9'd367;
			4'd3:    t = 9'd30;
			4'd4:    t = 9'd61;
			4'd5:    t = 9'd91;
			4'd6:    t = 9'd122;
			4'd7:    t = 9'd152;
			4'd8:    t = 9'd183;
			4'd9:    t = 9'd214;
			4'd10:   t = 9'd244;
			4'd11:   t = 9'd275;
			4'd12:   t = 9'd305;
			default: t = 9'd0;
		endcase
		return t;
	endfunction

endpackage

[hw/rtl/dtjd_date.sv]
// ----------------------------------------------------------------------------
// dtjd_date
// Four-stage date path: validation, leap rule and integer Julian day number.
// ----------------------------------------------------------------------------
module dtjd_date import dtjd_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  date_t       item,
	output logic        status_s4,
	output logic [24:0] day_number_s4
);

	// Stage 1: range checks, month tables, year / 100 product
	logic        basic_s1;
	logic [15:0] y_s1;
	logic [4:0]  d_s1;
	logic [4:0]  len_s1;
	logic        feb_s1;
	logic        early_s1;
	logic [8:0]  term2_s1;
	logic [33:0] yprod_s1;

	logic basic;
	assign basic = (item.year != 16'd0) && (item.month != 4'd0) &&
		(item.month <= MONTH_DEC) && (item.day != 5'd0) &&
		(item.hour < 5'd24) && (item.minute < 6'd60) && (item.second < 6'd60);

	always_ff @(posedge clk) begin
		if (en) begin
			basic_s1 <= basic;
			y_s1     <= item.year;
			d_s1     <= item.day;
			len_s1   <= month_len(item.month);
			feb_s1   <= (item.month == MONTH_FEB);
			early_s1 <= (item.month <= MONTH_FEB);
			term2_s1 <= month_term(item.month);
			yprod_s1 <= 34'(item.year) * 34'(RECIP_100);
		end
	end

	// Stage 2: century remainder, leap year, day check, 1461 * year term
	logic [9:0]  q100;
	logic        zero100;
	logic        leap;
	logic [4:0]  len_eff;
	logic [16:0] yadj;
	logic [26:0] t1_full;

	assign q100    = yprod_s1[33:24];
	assign zero100 = (y_s1 == 16'(16'(q100) * 16'd100));
	assign leap    = (y_s1[1:0] == 2'd0) && (!zero100 || (q100[1:0] == 2'd0));
	assign len_eff = (feb_s1 && leap) ? FEB_LEAP_LEN : len_s1;
	assign yadj    = 17'(y_s1) + YEAR_OFS - 17'(early_s1);
	assign t1_full = 27'(yadj) * DAYS_4YR;

	logic        ok_s2;
	logic [24:0] t1_s2;
	logic [9:0]  c_s2;
	logic [8:0]  term2_s2;
	logic [4:0]  d_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2    <= basic_s1 && (d_s1 <= len_eff);
			t1_s2    <= t1_full[26:2];
			// (y + 4900 - early) / 100 from the same quotient
			c_s2     <= q100 + CENT_OFS - 10'(zero100 && early_s1);
			term2_s2 <= term2_s1;
			d_s2     <= d_s1;
		end
	end

	// Stage 3: positive partial sum and century correction
	logic [11:0] c3;
	assign c3 = 12'(c_s2) * 12'd3;

	logic        ok_s3;
	logic [25:0] part_s3;
	logic [9:0]  t3_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s3   <= ok_s2;
			part_s3 <= 26'(t1_s2) + 26'(term2_s2) + 26'(d_s2) - JDN_BIAS;
			t3_s3   <= c3[11:2];
		end
	end

	// Stage 4: final day number, zeroed for an invalid date
	logic [25:0] jd;
	assign jd = part_s3 - 26'(t3_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			status_s4     <= !ok_s3;
			day_number_s4 <= ok_s3 ? jd[24:0] : 25'd0;
		end
	end

endmodule

[hw/rtl/dtjd_frac.sv]
// ----------------------------------------------------------------------------
// dtjd_frac
// Four-stage time path: seconds of day scaled to a fixed-point day fraction.
// ----------------------------------------------------------------------------
module dtjd_frac import dtjd_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	output logic [31:0] frac_s4
);

	// 2^EXP = QE * 675 + RE, so secs * 2^EXP / 675 = secs * QE + secs * RE / 675
	localparam int unsigned EXP   = FRACTION_BITS - DAY_SHIFT;
	localparam logic [63:0] POW   = 64'd1 << EXP;
	localparam logic [63:0] QE    = POW / DAY_ODD;
	localparam logic [63:0] RE    = POW % DAY_ODD;
	localparam logic [31:0] QE_LO = QE[31:0];
	localparam logic [9:0]  RE_W  = RE[9:0];

	// Stage 1: seconds of the day
	logic [16:0] secs_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			secs_s1 <= 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
		end
	end

	// Stage 2: whole-quotient product (low 32 bits only) and remainder product
	logic [31:0] lo_s2;
	logic [26:0] re_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2 <= 32'(secs_s1) * QE_LO;
			re_s2 <= 27'(secs_s1) * 27'(RE_W);
		end
	end

	// Stage 3: divide the remainder product by 675 through its reciprocal
	logic [31:0] lo_s3;
	logic [53:0] rq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3 <= lo_s2;
			rq_s3 <= 54'(re_s2) * 54'(RECIP_675);
		end
	end

	// Stage 4: sum, cut to 32 bits
	logic [17:0] q_rem;
	assign q_rem = rq_s3[RECIP_675_SHIFT +: 18];

	always_ff @(posedge clk) begin
		if (en) begin
			frac_s4 <= lo_s3 + 32'(q_rem);
		end
	end

endmodule

[hw/rtl/date_to_julian_day_top.sv]
// ----------------------------------------------------------------------------
// date_to_julian_day_top
// Calendar date and time of day to Julian day number and day fraction.
// ----------------------------------------------------------------------------
// Each transaction on the date channel carries a Gregorian date and a time of
// day; each gives exactly one transaction on the jd channel, in order, once it
// has passed through stages s1 to s4. While the output is not stalled the block
// takes one date every cycle: the rate is one transaction per cycle, through a
// four-stage pipeline that splits up the constant multiplies (year / 100 and the
// fraction reciprocals). An invalid date or time gives status 1 with day_number
// and day_fraction zero. A stall on the jd channel, while the output register
// holds a result, freezes the whole pipeline and is passed back to the date
// channel. There is no state beyond the pipeline; reset only empties it.
// ----------------------------------------------------------------------------
module date_to_julian_day_top import dtjd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  date_valid,
	output logic  date_stall,
	input  date_t date,
	output logic  jd_valid,
	input  logic  jd_stall,
	output jd_t   jd
);

	// Pipeline advance: hold everything while a finished result waits
	logic en;
	assign en         = !(jd_valid && jd_stall);
	assign date_stall = jd_valid && jd_stall;

	// Valid bits travelling with the data
	logic v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= date_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Datapaths
	logic        status_s4;
	logic [24:0] day_number_s4;
	logic [31:0] frac_s4;

	dtjd_date u_date (
		.clk           (clk),
		.en            (en),
		.item          (date),
		.status_s4     (status_s4),
		.day_number_s4 (day_number_s4)
	);

	dtjd_frac u_frac (
		.clk     (clk),
		.en      (en),
		.hour    (date.hour),
		.minute  (date.minute),
		.second  (date.second),
		.frac_s4 (frac_s4)
	);

	// Result transaction
	assign jd_valid        = v_s4;
	assign jd.status       = status_s4;
	assign jd.day_number   = day_number_s4;
	assign jd.day_fraction = status_s4 ? 32'd0 : frac_s4;

	// Checks
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(jd_valid && jd_stall) |-> date_stall)
		else $error("output stalled but input not held off");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(jd_valid && jd.status) |-> (jd.day_number == 25'd0 && jd.day_fraction == 32'd0))
		else $error("invalid date with non-zero result");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && en) |=> jd_valid)
		else $error("result lost in last pipeline stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(jd_valid && jd_stall) |=> (jd_valid && $stable(day_number_s4)))
		else $error("stalled result changed");

endmodule

[dv/tb_date_to_julian_day_top.sv]
// ----------------------------------------------------------------------------
// tb_date_to_julian_day_top
// Self-checking bench for the date to Julian day number pipeline.
// ----------------------------------------------------------------------------
// A queue of dates is filled at time zero. It holds a directed set: calendar
// edges, leap and century years, and every kind of out-of-range field. After
// that come random dates, mostly valid with a share of broken ones. A negedge
// driver presents them on the date channel. A posedge monitor predicts the
// day number and the day fraction of every accepted transaction. It checks
// each jd transaction against the oldest prediction, field by field. The run
// has three phases of back-pressure: sender idling light and receiver stalls
// heavy, then the reverse, then none. Some dates hold off until the pipeline
// has drained.
// ----------------------------------------------------------------------------
module tb_date_to_julian_day_top;
	import dtjd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NUM_RANDOM     = 880;
	localparam int unsigned NUM_PHASES     = 3;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES  = 16;
	localparam int unsigned SECONDS_IN_DAY = 86400;
	localparam int unsigned DATE_BITS      = $bits(date_t);

	// One date waiting to be sent, with its back-pressure phase
	typedef struct {
		date_t       date;
		int unsigned phase;
		bit          drain;
	} pending_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b1;
	logic  date_valid = 1'b0;
	logic  date_stall;
	date_t date = '0;
	logic  jd_valid;
	logic  jd_stall = 1'b0;
	jd_t   jd;

	pending_t    date_queue[$];
	jd_t         jd_expected[$];
	pending_t    next_date;
	int unsigned cur_phase = 0;
	bit          date_taken = 1'b0;
	bit          jd_taken = 1'b0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;

	date_to_julian_day_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.date_valid (date_valid),
		.date_stall (date_stall),
		.date       (date),
		.jd_valid   (jd_valid),
		.jd_stall   (jd_stall),
		.jd         (jd)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Gregorian month length; the month must already be 1 to 12
	function automatic int unsigned days_in_month(input logic [15:0] y, input logic [3:0] m);
		bit leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		if (m == MONTH_FEB)
			return leap ? 29 : 28;
		else if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		else
			return 31;
	endfunction

	function automatic bit date_ok(input date_t d);
		if (d.year == 0 || d.month == 0 || d.month > MONTH_DEC || d.day == 0)
			return 1'b0;
		if (d.hour >= 24 || d.minute >= 60 || d.second >= 60)
			return 1'b0;
		return d.day <= days_in_month(d.year, d.month);
	endfunction

	// Expected jd transaction for one date
	function automatic jd_t julian_day_of(input date_t d);
		jd_t            r;
		longint         y, m, dd, early, jdn;
		int unsigned    secs;
		logic [127:0]   scaled;
		r = '0;
		if (!date_ok(d)) begin
			r.status = 1'b1;
		end else begin
			y = d.year;
			m = d.month;
			dd = d.day;
			// year taken to start in March
			early = (d.month <= MONTH_FEB) ? -1 : 0;
			jdn = dd - 32075
				+ (1461 * (y + 4800 + early)) / 4
				+ (367 * (m - 2 - early * 12)) / 12
				- (3 * ((y + 4900 + early) / 100)) / 4;
			secs = d.hour * 3600 + d.minute * 60 + d.second;
			scaled = (128'(secs) << FRACTION_BITS) / 128'(SECONDS_IN_DAY);
			r.day_number = jdn[24:0];
			r.day_fraction = scaled[31:0];
		end
		return r;
	endfunction

	// Random date: mostly well formed, some with one field pushed out of range or all bits random
	function automatic date_t random_date();
		date_t       d;
		int unsigned len;
		int unsigned pick;
		case ($urandom_range(3))
			0: d.year = 16'($urandom_range(2100, 1));
			1: d.year = 16'($urandom_range(65535, 1));
			2: d.year = 16'($urandom_range(2401, 1599));
			default: d.year = $urandom_range(1) ? 16'($urandom_range(20, 1))
				: 16'($urandom_range(65535, 65500));
		endcase
		d.month = 4'($urandom_range(12, 1));
		len = days_in_month(d.year, d.month);
		d.day = 5'($urandom_range(len, 1));
		d.hour = 5'($urandom_range(23));
		d.minute = 6'($urandom_range(59));
		d.second = 6'($urandom_range(59));
		pick = $urandom_range(99);
		if (pick < 18) begin
			case ($urandom_range(6))
				0: d.year = '0;
				1: d.month = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
				2: d.day = (len == 31 || $urandom_range(1)) ? 5'd0 : 5'($urandom_range(31, len + 1));
				3: d.hour = 5'($urandom_range(31, 24));
				4: d.minute = 6'($urandom_range(63, 60));
				5: d.second = 6'($urandom_range(63, 60));
				default: d = DATE_BITS'({$urandom, $urandom});
			endcase
		end else if (pick < 26) begin
			// last day of the month
			d.day = 5'(len);
		end
		return d;
	endfunction

	function automatic date_t make_date(input int unsigned y, input int unsigned mo,
		input int unsigned d, input int unsigned h, input int unsigned mi, input int unsigned s);
		date_t r;
		r.year = 16'(y);
		r.month = 4'(mo);
		r.day = 5'(d);
		r.hour = 5'(h);
		r.minute = 6'(mi);
		r.second = 6'(s);
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	function automatic int unsigned idle_percent(input int unsigned phase, input bit receiver);
		case (phase)
			0: return receiver ? 59 : 28;
			1: return receiver ? 28 : 59;
			default: return 0;
		endcase
	endfunction

	// Stimulus, reset and end of run
	initial begin
		date_t directed[$];
		pending_t p;
		// nonblocking falling edge at time zero so the asynchronous reset is seen
		arst_n <= 1'b0;
		directed = '{
			make_date(1, 1, 1, 0, 0, 0),
			make_date(65535, 12, 31, 23, 59, 59),
			make_date(2000, 2, 29, 12, 0, 0),
			make_date(1900, 2, 29, 0, 0, 0),
			make_date(2024, 2, 29, 6, 30, 15),
			make_date(2023, 2, 29, 1, 2, 3),
			make_date(2023, 2, 28, 23, 59, 59),
			make_date(2000, 3, 1, 0, 0, 1),
			make_date(2000, 1, 1, 12, 0, 0),
			make_date(0, 6, 15, 10, 10, 10),
			make_date(1999, 0, 10, 0, 0, 0),
			make_date(1999, 13, 10, 0, 0, 0),
			make_date(1999, 15, 10, 0, 0, 0),
			make_date(1999, 5, 0, 0, 0, 0),
			make_date(1999, 4, 31, 0, 0, 0),
			make_date(1999, 7, 31, 0, 0, 0),
			make_date(1999, 7, 4, 24, 0, 0),
			make_date(1999, 7, 4, 31, 0, 0),
			make_date(1999, 7, 4, 0, 60, 0),
			make_date(1999, 7, 4, 0, 63, 0),
			make_date(1999, 7, 4, 0, 0, 60),
			make_date(1999, 7, 4, 0, 0, 63),
			make_date(65535, 15, 31, 31, 63, 63),
			make_date(1600, 2, 29, 23, 0, 0),
			make_date(2100, 2, 29, 0, 0, 0)
		};
		foreach (directed[i]) begin
			p.date = directed[i];
			p.phase = 0;
			p.drain = 1'b0;
			date_queue.push_back(p);
		end
		for (int unsigned i = 0; i < NUM_RANDOM; i++) begin
			p.date = random_date();
			p.phase = (i * NUM_PHASES) / NUM_RANDOM;
			// hold off at each phase change and now and then in between
			p.drain = (i != 0 && (i * NUM_PHASES) % NUM_RANDOM < NUM_PHASES)
				|| ($urandom_range(99) == 0);
			date_queue.push_back(p);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (date_queue.size() != 0 || date_valid)
			@(posedge clk);
		while (jd_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		foreach (jd_expected[i])
			report_mismatch($sformatf("result never came, status %0b day_number %0d",
				jd_expected[i].status, jd_expected[i].day_number));
		if (mismatches == 0)
			$display("[date_to_julian_day_top] OK");
		else
			$display("[date_to_julian_day_top] ERROR");
		$finish;
	end

	// Date channel driver: new transaction only once the last one has gone
	always @(negedge clk) begin
		if (arst_n) begin
			if (!date_valid || date_taken) begin
				if (date_queue.size() != 0
					&& !(date_queue[0].drain && jd_expected.size() != 0)
					&& $urandom_range(99) >= idle_percent(date_queue[0].phase, 1'b0)) begin
					next_date = date_queue.pop_front();
					date <= next_date.date;
					date_valid <= 1'b1;
					cur_phase <= next_date.phase;
				end else begin
					date_valid <= 1'b0;
				end
			end
		end
	end

	// jd channel back-pressure
	always @(negedge clk) begin
		if (!arst_n)
			jd_stall <= 1'b0;
		else
			jd_stall <= ($urandom_range(99) < idle_percent(cur_phase, 1'b1));
	end

	// Monitor: predict on the date side, check on the jd side, watch for hangs
	always @(posedge clk) begin
		jd_t want;
		date_taken = date_valid && !date_stall;
		jd_taken = jd_valid && !jd_stall;
		if (date_taken)
			jd_expected.push_back(julian_day_of(date));
		if (jd_taken) begin
			if (jd_expected.size() == 0) begin
				report_mismatch($sformatf("unexpected result, status %0b day_number %0d",
					jd.status, jd.day_number));
			end else begin
				want = jd_expected.pop_front();
				if (jd.status !== want.status)
					report_mismatch($sformatf("status %0b, want %0b", jd.status, want.status));
				if (jd.day_number !== want.day_number)
					report_mismatch($sformatf("day_number %0d, want %0d",
						jd.day_number, want.day_number));
				if (jd.day_fraction !== want.day_fraction)
					report_mismatch($sformatf("day_fraction %0h, want %0h",
						jd.day_fraction, want.day_fraction));
			end
		end
		if (!arst_n || date_taken || jd_taken)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[date_to_julian_day_top] ERROR");
			$finish;
		end
	end

endmodule

[filelist.f]
hw/rtl/dtjd_pkg.sv
hw/rtl/dtjd_date.sv
hw/rtl/dtjd_frac.sv
hw/rtl/date_to_julian_day_top.sv
dv/tb_date_to_julian_day_top.sv
